FILE: sv/lsms_pkg.sv
// Package with the types and constants of the LCD scanline mode sequencer.
package lsms_pkg;

   // LCD modes as shown on the result word.
   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   // Configuration register indexes (byte address is four times the index).
   typedef enum logic [1:0] {
      REG_DISPLAY_ENABLE = 2'd0,
      REG_LINE_COMPARE   = 2'd1,
      REG_STAT_ENABLES   = 2'd2,
      REG_NONE           = 2'd3
   } reg_index_type;

   // Mode lengths in machine cycles.
   localparam logic [9:0] OAM_CYCLES    = 10'd80;
   localparam logic [9:0] XFER_CYCLES   = 10'd172;
   localparam logic [9:0] HBLANK_CYCLES = 10'd204;
   localparam logic [9:0] LINE_CYCLES   = 10'd456;

   // Line numbers that bound the visible area and the frame.
   localparam logic [7:0] VBLANK_LINE = 8'd144;
   localparam logic [7:0] LAST_LINE   = 8'd153;

   // Bit of the interrupt enables that arms the line compare interrupt.
   localparam int unsigned COINC_ENABLE_BIT = 3;

   // Configuration seen by the step logic.
   typedef struct packed {
      logic       display_enable;
      logic [7:0] line_compare;
      logic [3:0] stat_irq_enables;
   } cfg_type;

   // Sequencer state carried from one word to the next.
   typedef struct packed {
      mode_type   mode;
      logic [9:0] dot_count;
      logic [7:0] line;
      mode_type   previous_mode;
   } state_type;

   // One result word.
   typedef struct packed {
      logic [7:0] line_count;
      mode_type   lcd_mode;
      logic       coincidence;
      logic       vblank_irq;
      logic       stat_irq;
      logic       scanline_draw;
      logic       frame_done;
   } result_type;

endpackage

FILE: sv/lsms_req_if.sv
// Valid/ready channel that carries the elapsed cycle count of one step.
interface lsms_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] elapsed_cycles;

   modport source (output valid, output elapsed_cycles, input ready);
   modport sink (input valid, input elapsed_cycles, output ready);
endinterface

FILE: sv/lsms_rsp_if.sv
// Valid/ready channel that carries one sequencer result word.
interface lsms_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_count;
   logic [1:0] lcd_mode;
   logic       coincidence;
   logic       vblank_irq;
   logic       stat_irq;
   logic       scanline_draw;
   logic       frame_done;

   modport source (
      output valid, output line_count, output lcd_mode, output coincidence,
      output vblank_irq, output stat_irq, output scanline_draw, output frame_done,
      input ready
   );
   modport sink (
      input valid, input line_count, input lcd_mode, input coincidence,
      input vblank_irq, input stat_irq, input scanline_draw, input frame_done,
      output ready
   );
endinterface

FILE: sv/lsms_csr.sv
// APB-style configuration registers of the scanline mode sequencer.
module lsms_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output lsms_pkg::cfg_type cfg
);

   logic       display_enable_ff;
   logic [7:0] line_compare_ff;
   logic [3:0] stat_enables_ff;
   logic       wr_en;
   lsms_pkg::reg_index_type index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = lsms_pkg::reg_index_type'(paddr[3:2]);

   // Register writes; an address past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         display_enable_ff <= 1'b1;
         line_compare_ff   <= 8'd0;
         stat_enables_ff   <= 4'd0;
      end else if (wr_en) begin
         unique case (index)
            lsms_pkg::REG_DISPLAY_ENABLE: display_enable_ff <= pwdata[0];
            lsms_pkg::REG_LINE_COMPARE:   line_compare_ff   <= pwdata[7:0];
            lsms_pkg::REG_STAT_ENABLES:   stat_enables_ff   <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      unique case (index)
         lsms_pkg::REG_DISPLAY_ENABLE: prdata = {31'd0, display_enable_ff};
         lsms_pkg::REG_LINE_COMPARE:   prdata = {24'd0, line_compare_ff};
         lsms_pkg::REG_STAT_ENABLES:   prdata = {28'd0, stat_enables_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   assign cfg.display_enable   = display_enable_ff;
   assign cfg.line_compare     = line_compare_ff;
   assign cfg.stat_irq_enables = stat_enables_ff;

endmodule

FILE: sv/lsms_step.sv
// Next-state and result logic for one step of the scanline mode sequencer.
module lsms_step (
   input  lsms_pkg::cfg_type    cfg,
   input  lsms_pkg::state_type  cur,
   input  logic [7:0]           elapsed_cycles,
   output lsms_pkg::state_type  nxt,
   output lsms_pkg::result_type res
);

   logic [9:0]  clock_new;
   logic [7:0]  line_inc;
   logic        stat_entry;
   logic        coinc;

   // The 10-bit count holds every sum without wrapping.
   assign clock_new = cur.dot_count + {2'd0, elapsed_cycles};
   assign line_inc  = cur.line + 8'd1;

   // Mode sequence: advance on the end of the current mode, drop excess cycles.
   always_comb begin
      nxt           = cur;
      res           = '0;
      stat_entry    = 1'b0;
      coinc         = 1'b0;
      if (!cfg.display_enable) begin
         nxt.line = 8'd0;
         nxt.mode = lsms_pkg::MODE_HBLANK;
      end else begin
         nxt.dot_count = clock_new;
         unique case (cur.mode)
            lsms_pkg::MODE_OAM: begin
               if (clock_new >= lsms_pkg::OAM_CYCLES) begin
                  nxt.dot_count = 10'd0;
                  nxt.mode      = lsms_pkg::MODE_XFER;
               end
            end
            lsms_pkg::MODE_XFER: begin
               if (clock_new >= lsms_pkg::XFER_CYCLES) begin
                  nxt.dot_count     = 10'd0;
                  nxt.mode          = lsms_pkg::MODE_HBLANK;
                  res.scanline_draw = 1'b1;
               end
            end
            lsms_pkg::MODE_HBLANK: begin
               if (clock_new >= lsms_pkg::HBLANK_CYCLES) begin
                  nxt.dot_count = 10'd0;
                  nxt.line      = line_inc;
                  if (line_inc == lsms_pkg::VBLANK_LINE) begin
                     nxt.mode       = lsms_pkg::MODE_VBLANK;
                     res.vblank_irq = 1'b1;
                     res.frame_done = 1'b1;
                  end else begin
                     nxt.mode = lsms_pkg::MODE_OAM;
                  end
               end
            end
            default: begin
               if (clock_new >= lsms_pkg::LINE_CYCLES) begin
                  nxt.dot_count = 10'd0;
                  nxt.line      = line_inc;
                  if (line_inc > lsms_pkg::LAST_LINE) begin
                     nxt.mode = lsms_pkg::MODE_OAM;
                     nxt.line = 8'd0;
                  end
               end
            end
         endcase

         // Status interrupt on entry to an enabled mode, or on line match.
         if (cur.previous_mode != nxt.mode) begin
            nxt.previous_mode = nxt.mode;
            stat_entry = (nxt.mode != lsms_pkg::MODE_XFER) &&
                         cfg.stat_irq_enables[nxt.mode];
         end
         coinc        = (nxt.line == cfg.line_compare);
         res.stat_irq = stat_entry ||
                        (coinc && cfg.stat_irq_enables[lsms_pkg::COINC_ENABLE_BIT]);
      end
      res.line_count  = nxt.line;
      res.lcd_mode    = nxt.mode;
      res.coincidence = (nxt.line == cfg.line_compare);
   end

endmodule

FILE: sv/lcd_scanline_mode_sequencer.sv
// LCD scanline mode sequencer: top level with input and result registers.
//
// The req channel carries one word per step: the machine cycles elapsed since
// the previous step. For every accepted word the rsp channel delivers exactly
// one result word: line counter, LCD mode, line compare coincidence and the
// v-blank, status interrupt, scanline-draw and frame-done pulses of that step.
// The user writes configuration (display enable, line compare, interrupt
// enables) via the APB-style port only while no word is in flight (unenforced).
//
// A word is registered in the input register on acceptance; the sequencer
// state and result are computed from it and land in the result register.
// One word is taken per cycle while the receiver takes results; the state
// register updates as each word moves to the result register, so each word
// sees the state left by the one before.
//
// Reset clears the sequencer to line 0, h-blank, mode clock 0, enables the
// display and empties both registers. When the receiver stalls, the result
// register holds its word and the input register keeps one more word; the
// req channel then drops ready until the result is taken.
module lcd_scanline_mode_sequencer (
   input  logic        clock,
   input  logic        reset,
   lsms_req_if.sink    req_chan,
   lsms_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   lsms_pkg::cfg_type    cfg;
   lsms_pkg::state_type  state_ff;
   lsms_pkg::state_type  state_in;
   lsms_pkg::result_type result_in;
   lsms_pkg::result_type result_ff;
   logic                 in_valid_ff;
   logic [7:0]           in_cycles_ff;
   logic                 out_valid_ff;
   logic                 out_free;
   logic                 advance;

   lsms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lsms_step u_step (
      .cfg            (cfg),
      .cur            (state_ff),
      .elapsed_cycles (in_cycles_ff),
      .nxt            (state_in),
      .res            (result_in)
   );

   // Handshake: the input word moves on whenever the result register is free.
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         in_cycles_ff <= req_chan.elapsed_cycles;
      end
   end

   // Sequencer state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.line_count    = result_ff.line_count;
   assign rsp_chan.lcd_mode      = result_ff.lcd_mode;
   assign rsp_chan.coincidence   = result_ff.coincidence;
   assign rsp_chan.vblank_irq    = result_ff.vblank_irq;
   assign rsp_chan.stat_irq      = result_ff.stat_irq;
   assign rsp_chan.scanline_draw = result_ff.scanline_draw;
   assign rsp_chan.frame_done    = result_ff.frame_done;

endmodule

FILE: sv/lsms_checker.sv
// Port-level assertions for the scanline mode sequencer, bound to its top level.
module lsms_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_line_count,
   input logic [1:0] rsp_lcd_mode,
   input logic       rsp_vblank_irq,
   input logic       rsp_scanline_draw,
   input logic       rsp_frame_done
);

   // V-blank mode is shown exactly on the lines past the visible area.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_lcd_mode == lsms_pkg::MODE_VBLANK) ==
                     (rsp_line_count >= lsms_pkg::VBLANK_LINE)))
      else $error("v-blank mode and line counter disagree");

   // The v-blank interrupt and the frame-done pulse always come together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_vblank_irq == rsp_frame_done))
      else $error("v-blank interrupt without frame done");

   // A frame ends on entry to the first v-blank line.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |->
         (rsp_lcd_mode == lsms_pkg::MODE_VBLANK &&
          rsp_line_count == lsms_pkg::VBLANK_LINE))
      else $error("frame done outside v-blank entry");

   // A drawn line always leaves the sequencer in h-blank.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scanline_draw) |-> (rsp_lcd_mode == lsms_pkg::MODE_HBLANK))
      else $error("scanline drawn without h-blank");

   // A stalled result word stays put.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_line_count) && $stable(rsp_lcd_mode)))
      else $error("stalled result word changed");

endmodule

bind lcd_scanline_mode_sequencer lsms_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_line_count    (rsp_chan.line_count),
   .rsp_lcd_mode      (rsp_chan.lcd_mode),
   .rsp_vblank_irq    (rsp_chan.vblank_irq),
   .rsp_scanline_draw (rsp_chan.scanline_draw),
   .rsp_frame_done    (rsp_chan.frame_done)
);
